/* rtl/core/ech_pkg.sv */
// Shared types, fixed-point widths and constant tables for the e-compass heading pipeline.
package ech_pkg;

  localparam int unsigned SampleW  = 16;
  localparam int unsigned HeadingW = 15;
  localparam int unsigned FracBits = 6;
  localparam int unsigned AngFrac  = 16;
  localparam int unsigned CordicN  = 20;
  localparam int unsigned RootN    = 30;
  localparam int unsigned RootFrac = 28;

  localparam logic signed [17:0] FullTurn = 18'sd23040;
  localparam logic signed [27:0] HalfTurnZ = 28'sd11796480;
  localparam logic signed [27:0] RoundHalf = 28'sd512;

  localparam logic signed [27:0] AtanTab [CordicN] = '{
    28'sd2949120, 28'sd1740967, 28'sd919879, 28'sd466945, 28'sd234379,
    28'sd117304, 28'sd58666, 28'sd29335, 28'sd14668, 28'sd7334,
    28'sd3667, 28'sd1833, 28'sd917, 28'sd458, 28'sd229,
    28'sd115, 28'sd57, 28'sd29, 28'sd14, 28'sd7
  };

  typedef struct packed {
    logic signed [SampleW-1:0] accel_x;
    logic signed [SampleW-1:0] accel_y;
    logic signed [SampleW-1:0] accel_z;
    logic signed [SampleW-1:0] mag_x;
    logic signed [SampleW-1:0] mag_y;
    logic signed [SampleW-1:0] mag_z;
  } ech_in_t;

  typedef struct packed {
    logic [HeadingW-1:0] heading;
    logic                heading_valid;
  } ech_out_t;

  // Per-item values carried alongside the square root.
  typedef struct packed {
    logic               valid;
    logic               wzero;
    logic signed [32:0] wx;
    logic signed [50:0] nx;
  } ech_side_t;

  // Flags carried through the angle stages.
  typedef struct packed {
    logic valid;
    logic wzero;
    logic zh;
  } ech_flg_t;

endpackage

/* rtl/core/ecompass_heading_from_vectors.sv */
// Tilt-compensated compass heading: top level of the pipelined datapath.
// An accepted input transfer reaches its result transfer through 4 front stages,
// 30 square-root stages (one root bit each), 3 scale and normalization stages,
// 20 CORDIC stages and the output register.
// Throughput is one transfer per cycle while the output side does not stall.
// Reset clears all valid bits; the data registers hold whatever they held.
module ecompass_heading_from_vectors (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ech_pkg::ech_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ech_pkg::ech_out_t out_data_o
);
  import ech_pkg::*;

  // The whole pipeline moves as one. It freezes only when a finished result
  // sits in the output register and the receiver stalls it, so bubbles and
  // items alike hold their place and nothing is dropped or repeated.
  logic en;

  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  ech_side_t   side_f, side_s;
  logic [59:0] rem_f;
  logic [29:0] root_s;

  // Up = -accel, west = up x mag, north x term and |up|^2 scaled for the root.
  ech_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(in_valid_i),
    .data_i (in_data_i),
    .side_o (side_f),
    .rem_o  (rem_f)
  );

  // Because north is perpendicular to up, |north| = |west| * |up|, so only
  // |up| needs a root; the angle is atan2(wx * |up|, nx).
  ech_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .side_i (side_f),
    .rem_i  (rem_f),
    .side_o (side_s),
    .root_o (root_s)
  );

  // Scaling, CORDIC vectoring and rounding to 1/64 degree; the last register
  // of this unit is the output register seen on the result channel.
  ech_angle u_angle (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .side_i (side_s),
    .root_i (root_s),
    .valid_o(out_valid_o),
    .data_o (out_data_o)
  );

endmodule

/* rtl/core/ech_front.sv */
// Front stages: up vector, west cross product, north x term and squared length of up.
module ech_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  ech_pkg::ech_in_t data_i,
  output ech_pkg::ech_side_t side_o,
  output logic [59:0]      rem_o
);
  import ech_pkg::*;

  logic signed [16:0] ux, uy, uz;
  logic signed [15:0] mx, my, mz;

  assign ux = -17'(data_i.accel_x);
  assign uy = -17'(data_i.accel_y);
  assign uz = -17'(data_i.accel_z);
  assign mx = data_i.mag_x;
  assign my = data_i.mag_y;
  assign mz = data_i.mag_z;

  // Stage 1: products.
  logic               v1_q;
  logic signed [31:0] p0_q, p1_q, p2_q, p3_q, p4_q, p5_q;
  logic [30:0]        sq0_q, sq1_q, sq2_q;
  logic signed [16:0] uy1_q, uz1_q;
  logic signed [33:0] s0, s1, s2;

  assign s0 = 34'(ux) * 34'(ux);
  assign s1 = 34'(uy) * 34'(uy);
  assign s2 = 34'(uz) * 34'(uz);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p0_q  <= 32'(uy) * 32'(mz);
      p1_q  <= 32'(uz) * 32'(my);
      p2_q  <= 32'(uz) * 32'(mx);
      p3_q  <= 32'(ux) * 32'(mz);
      p4_q  <= 32'(ux) * 32'(my);
      p5_q  <= 32'(uy) * 32'(mx);
      sq0_q <= 31'(s0);
      sq1_q <= 31'(s1);
      sq2_q <= 31'(s2);
      uy1_q <= uy;
      uz1_q <= uz;
    end
  end

  // Stage 2: west vector and squared length.
  logic               v2_q;
  logic signed [32:0] wx2_q, wy2_q, wz2_q;
  logic [31:0]        usq2_q;
  logic signed [16:0] uy2_q, uz2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      wx2_q  <= 33'(p0_q) - 33'(p1_q);
      wy2_q  <= 33'(p2_q) - 33'(p3_q);
      wz2_q  <= 33'(p4_q) - 33'(p5_q);
      usq2_q <= 32'(sq0_q) + 32'(sq1_q) + 32'(sq2_q);
      uy2_q  <= uy1_q;
      uz2_q  <= uz1_q;
    end
  end

  // Stage 3: north x products and zero test on west.
  logic               v3_q, wz3_q;
  logic signed [49:0] pn0_q, pn1_q;
  logic signed [32:0] wx3_q;
  logic [31:0]        usq3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en_i) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pn0_q  <= 50'(wy2_q) * 50'(uz2_q);
      pn1_q  <= 50'(wz2_q) * 50'(uy2_q);
      wz3_q  <= (wx2_q == '0) && (wy2_q == '0) && (wz2_q == '0);
      wx3_q  <= wx2_q;
      usq3_q <= usq2_q;
    end
  end

  // Stage 4: north x term.
  logic        v4_q, wz4_q;
  logic signed [32:0] wx4_q;
  logic signed [50:0] nx4_q;
  logic [31:0]        usq4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en_i) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nx4_q  <= 51'(pn0_q) - 51'(pn1_q);
      wz4_q  <= wz3_q;
      wx4_q  <= wx3_q;
      usq4_q <= usq3_q;
    end
  end

  assign side_o.valid = v4_q;
  assign side_o.wzero = wz4_q;
  assign side_o.wx    = wx4_q;
  assign side_o.nx    = nx4_q;
  assign rem_o        = {usq4_q, RootFrac'(0)};

endmodule

/* rtl/core/ech_sqrt.sv */
// Pipelined integer square root, one result bit per stage.
module ech_sqrt (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  ech_pkg::ech_side_t side_i,
  input  logic [59:0]        rem_i,
  output ech_pkg::ech_side_t side_o,
  output logic [29:0]        root_o
);
  import ech_pkg::*;

  logic [60:0]        rem_q [RootN];
  logic [60:0]        res_q [RootN];
  logic               vld_q [RootN];
  logic               wzero_q [RootN];
  logic signed [32:0] wx_q [RootN];
  logic signed [50:0] nx_q [RootN];
  logic [60:0]        rem_in [RootN];
  logic [60:0]        res_in [RootN];
  logic [60:0]        rem_d [RootN];
  logic [60:0]        res_d [RootN];

  always_comb begin
    logic [60:0] bitv;
    logic [60:0] trial;
    rem_in[0] = 61'(rem_i);
    res_in[0] = '0;
    for (int j = 1; j < RootN; j++) begin
      rem_in[j] = rem_q[j-1];
      res_in[j] = res_q[j-1];
    end
    for (int j = 0; j < RootN; j++) begin
      bitv  = 61'(1) << (2 * (RootN - 1 - j));
      trial = res_in[j] + bitv;
      if (rem_in[j] >= trial) begin
        rem_d[j] = rem_in[j] - trial;
        res_d[j] = (res_in[j] >> 1) + bitv;
      end else begin
        rem_d[j] = rem_in[j];
        res_d[j] = res_in[j] >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < RootN; j++) begin
        vld_q[j] <= 1'b0;
      end
    end else if (en_i) begin
      vld_q[0] <= side_i.valid;
      for (int j = 1; j < RootN; j++) begin
        vld_q[j] <= vld_q[j-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      wzero_q[0] <= side_i.wzero;
      wx_q[0]    <= side_i.wx;
      nx_q[0]    <= side_i.nx;
      for (int j = 1; j < RootN; j++) begin
        wzero_q[j] <= wzero_q[j-1];
        wx_q[j]    <= wx_q[j-1];
        nx_q[j]    <= nx_q[j-1];
      end
      for (int j = 0; j < RootN; j++) begin
        rem_q[j] <= rem_d[j];
        res_q[j] <= res_d[j];
      end
    end
  end

  assign side_o.valid = vld_q[RootN-1];
  assign side_o.wzero = wzero_q[RootN-1];
  assign side_o.wx    = wx_q[RootN-1];
  assign side_o.nx    = nx_q[RootN-1];
  assign root_o       = res_q[RootN-1][29:0];

endmodule

/* rtl/core/ech_angle.sv */
// Angle stages: scale, range normalization, vectoring CORDIC and heading rounding.
module ech_angle (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  ech_pkg::ech_side_t side_i,
  input  logic [29:0]        root_i,
  output logic               valid_o,
  output ech_pkg::ech_out_t  data_o
);
  import ech_pkg::*;

  // Stage M: y = wx * root.
  ech_flg_t           fm_q;
  logic signed [63:0] xm_q, ym_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fm_q <= '0;
    end else if (en_i) begin
      fm_q.valid <= side_i.valid;
      fm_q.wzero <= side_i.wzero;
      fm_q.zh    <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xm_q <= 64'(side_i.nx);
      ym_q <= 64'(side_i.wx) * 64'($signed({1'b0, root_i}));
    end
  end

  // Stage N1: zero test, magnitude and coarse shifts.
  ech_flg_t           f1_q;
  logic signed [63:0] x1_q, y1_q;
  logic [61:0]        big1_q;
  logic signed [63:0] x1_d, y1_d;
  logic [61:0]        big1_d;

  always_comb begin
    logic [61:0] ax, ay;
    ax = xm_q[63] ? 62'(-xm_q) : 62'(xm_q);
    ay = ym_q[63] ? 62'(-ym_q) : 62'(ym_q);
    big1_d = (ax > ay) ? ax : ay;
    x1_d = xm_q;
    y1_d = ym_q;
    for (int k = 5; k >= 3; k--) begin
      if (big1_d >= (62'(1) << (28 + (1 << k)))) begin
        big1_d = big1_d >> (1 << k);
        x1_d   = x1_d >>> (1 << k);
        y1_d   = y1_d >>> (1 << k);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_q <= '0;
    end else if (en_i) begin
      f1_q.valid <= fm_q.valid;
      f1_q.wzero <= fm_q.wzero;
      f1_q.zh    <= (xm_q == '0) && (ym_q == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x1_q   <= x1_d;
      y1_q   <= y1_d;
      big1_q <= big1_d;
    end
  end

  // Stage N2: fine shifts and half-turn for negative x.
  ech_flg_t           f2_q;
  logic signed [33:0] x2_q, y2_q;
  logic signed [27:0] z2_q;
  logic signed [33:0] x2_d, y2_d;
  logic signed [27:0] z2_d;

  always_comb begin
    logic [61:0]        big;
    logic signed [63:0] xs, ys;
    big = big1_q;
    xs  = x1_q;
    ys  = y1_q;
    for (int k = 2; k >= 0; k--) begin
      if (big >= (62'(1) << (28 + (1 << k)))) begin
        big = big >> (1 << k);
        xs  = xs >>> (1 << k);
        ys  = ys >>> (1 << k);
      end
    end
    if (xs[63]) begin
      x2_d = -34'(xs);
      y2_d = -34'(ys);
      z2_d = HalfTurnZ;
    end else begin
      x2_d = 34'(xs);
      y2_d = 34'(ys);
      z2_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f2_q <= '0;
    end else if (en_i) begin
      f2_q <= f1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x2_q <= x2_d;
      y2_q <= y2_d;
      z2_q <= z2_d;
    end
  end

  // CORDIC vectoring stages, one rotation each.
  ech_flg_t           fc_q [CordicN];
  logic signed [33:0] cx_q [CordicN];
  logic signed [33:0] cy_q [CordicN];
  logic signed [27:0] cz_q [CordicN];
  logic signed [33:0] cx_in [CordicN];
  logic signed [33:0] cy_in [CordicN];
  logic signed [27:0] cz_in [CordicN];
  logic signed [33:0] cx_d [CordicN];
  logic signed [33:0] cy_d [CordicN];
  logic signed [27:0] cz_d [CordicN];

  always_comb begin
    cx_in[0] = x2_q;
    cy_in[0] = y2_q;
    cz_in[0] = z2_q;
    for (int i = 1; i < CordicN; i++) begin
      cx_in[i] = cx_q[i-1];
      cy_in[i] = cy_q[i-1];
      cz_in[i] = cz_q[i-1];
    end
    for (int i = 0; i < CordicN; i++) begin
      if (cy_in[i] > 0) begin
        cx_d[i] = cx_in[i] + (cy_in[i] >>> i);
        cy_d[i] = cy_in[i] - (cx_in[i] >>> i);
        cz_d[i] = cz_in[i] + AtanTab[i];
      end else begin
        cx_d[i] = cx_in[i] - (cy_in[i] >>> i);
        cy_d[i] = cy_in[i] + (cx_in[i] >>> i);
        cz_d[i] = cz_in[i] - AtanTab[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CordicN; i++) begin
        fc_q[i] <= '0;
      end
    end else if (en_i) begin
      fc_q[0] <= f2_q;
      for (int i = 1; i < CordicN; i++) begin
        fc_q[i] <= fc_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < CordicN; i++) begin
        cx_q[i] <= cx_d[i];
        cy_q[i] <= cy_d[i];
        cz_q[i] <= cz_d[i];
      end
    end
  end

  // Output stage: round to the heading grid and wrap once into a full turn.
  logic               vo_q;
  ech_out_t           out_q;
  ech_out_t           out_d;

  always_comb begin
    logic signed [27:0] zr;
    logic signed [17:0] h;
    zr = (cz_q[CordicN-1] + RoundHalf) >>> (AngFrac - FracBits);
    h  = 18'(zr);
    if (h < 0) begin
      h = h + FullTurn;
    end
    if (h >= FullTurn) begin
      h = h - FullTurn;
    end
    out_d.heading_valid = !fc_q[CordicN-1].wzero;
    if (fc_q[CordicN-1].wzero || fc_q[CordicN-1].zh) begin
      out_d.heading = '0;
    end else begin
      out_d.heading = h[HeadingW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en_i) begin
      vo_q <= fc_q[CordicN-1].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q <= out_d;
    end
  end

  assign valid_o = vo_q;
  assign data_o  = out_q;

endmodule

/* tb/ecompass_heading_from_vectors_tb.sv */
// Self-checking testbench for the pipelined tilt-compensated compass heading block.
`timescale 1ns / 100ps

module ecompass_heading_from_vectors_tb;
  import ech_pkg::*;

  // The scoreboard computes the expected heading for each accepted input transfer.
  // It uses plain 64-bit integer math that mirrors the datapath.
  // Expected results are compared in order against the output transfers.
  class heading_scoreboard;
    ech_out_t headings_due[$];
    int       mismatches;

    function new();
      mismatches = 0;
    endfunction

    // Integer square root, one result bit per pass.
    function longint unsigned root_floor(longint unsigned v);
      longint unsigned res;
      longint unsigned bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v   = v - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    // Angle of (x, y) in 2^-16 degree, found by CORDIC vectoring.
    function longint vector_angle(longint x, longint y);
      longint ax, ay, big, z, dx, dy;
      int     s;
      ax = (x < 0) ? -x : x;
      ay = (y < 0) ? -y : y;
      big = (ax > ay) ? ax : ay;
      s = 0;
      z = 0;
      while ((big >>> s) >= (64'sd1 <<< 29)) s++;
      x = x >>> s;
      y = y >>> s;
      // A vector in the left half plane is turned by half a turn first.
      if (x < 0) begin
        x = -x;
        y = -y;
        z = longint'(HalfTurnZ);
      end
      for (int i = 0; i < CordicN; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y > 0) begin
          x = x + dx;
          y = y - dy;
          z = z + longint'(AtanTab[i]);
        end else begin
          x = x - dx;
          y = y + dy;
          z = z - longint'(AtanTab[i]);
        end
      end
      return z;
    endfunction

    function ech_out_t heading_of(ech_in_t v);
      ech_out_t        res;
      longint          ux, uy, uz, mx, my, mz, wx, wy, wz, nx, ny, nz, yv, z, h;
      longint unsigned usq, r;
      ux = -longint'(v.accel_x);
      uy = -longint'(v.accel_y);
      uz = -longint'(v.accel_z);
      mx = longint'(v.mag_x);
      my = longint'(v.mag_y);
      mz = longint'(v.mag_z);
      res = '0;
      // West is up cross field; a zero west gives an invalid heading.
      wx = uy * mz - uz * my;
      wy = uz * mx - ux * mz;
      wz = ux * my - uy * mx;
      if (wx == 0 && wy == 0 && wz == 0) return res;
      // North is west cross up. At 16-bit samples west needs no shift.
      nx = wy * uz - wz * uy;
      ny = wz * ux - wx * uz;
      nz = wx * uy - wy * ux;
      if (nx == 0 && ny == 0 && nz == 0) return res;
      usq = longint'(ux * ux + uy * uy + uz * uz);
      r = root_floor(usq << RootFrac);
      yv = wx * longint'(r);
      res.heading_valid = 1'b1;
      // With up along x the direction is undefined and the heading stays 0.
      if (yv == 0 && nx == 0) return res;
      z = vector_angle(nx, yv);
      h = (z + longint'(RoundHalf)) >>> (AngFrac - FracBits);
      if (h < 0) h = h + longint'(FullTurn);
      if (h >= longint'(FullTurn)) h = h - longint'(FullTurn);
      res.heading = h[HeadingW-1:0];
      return res;
    endfunction

    function void note_input(ech_in_t v);
      headings_due.push_back(heading_of(v));
    endfunction

    function void check_result(ech_out_t got);
      ech_out_t exp_res;
      if (headings_due.size() == 0) begin
        $error("output transfer with no result pending: heading=%0d valid=%0b",
               got.heading, got.heading_valid);
        mismatches++;
        return;
      end
      exp_res = headings_due.pop_front();
      if (got.heading !== exp_res.heading) begin
        $error("heading: expected %0d, actual %0d", exp_res.heading, got.heading);
        mismatches++;
      end
      if (got.heading_valid !== exp_res.heading_valid) begin
        $error("heading_valid: expected %0b, actual %0b",
               exp_res.heading_valid, got.heading_valid);
        mismatches++;
      end
    endfunction

    function int pending();
      return headings_due.size();
    endfunction
  endclass

  localparam int RandomItems = 950;
  localparam int DrainCycles = 80;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  ech_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_stall_i;
  ech_out_t out_data_o;

  heading_scoreboard sb;
  int                cycle_cnt;

  ecompass_heading_from_vectors DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // Both transfers are seen at the rising edge, where inputs set at the
  // falling edge are stable.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_input(in_data_i);
      if (out_valid_o && !out_stall_i) sb.check_result(out_data_o);
    end
  end

  // The receiver cycles through stall patterns: none, light random, periodic
  // blocks and heavy random, so that stalls land on every point of the pipeline.
  always @(negedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    case ((cycle_cnt / 300) % 4)
      0: begin
        out_stall_i <= 1'b0;
      end
      1: begin
        out_stall_i <= ($urandom_range(0, 99) < 30);
      end
      2: begin
        out_stall_i <= ((cycle_cnt % 23) < 9);
      end
      default: begin
        out_stall_i <= ($urandom_range(0, 99) < 75);
      end
    endcase
  end

  // Drives one item and holds it until the block takes the transfer.
  // Valid stays high from the previous item, so it is only ever raised here.
  task automatic send_item(input ech_in_t v);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= v;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic idle_gap(input int cycles);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    in_data_i  <= ech_in_t'({$urandom, $urandom, $urandom});
    repeat (cycles) @(negedge clk_i);
  endtask

  function automatic ech_in_t pack_item(int ax, int ay, int az, int mx, int my, int mz);
    ech_in_t v;
    v.accel_x = ax[15:0];
    v.accel_y = ay[15:0];
    v.accel_z = az[15:0];
    v.mag_x   = mx[15:0];
    v.mag_y   = my[15:0];
    v.mag_z   = mz[15:0];
    return v;
  endfunction

  function automatic int rand_s16();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  // Random item: most are a plausible gravity plus field pair, the rest are
  // full-range noise, tiny values, parallel vectors or gravity along x.
  function automatic ech_in_t random_item();
    int sel, k, ax, ay, az;
    sel = $urandom_range(0, 99);
    ax = rand_s16();
    ay = rand_s16();
    az = rand_s16();
    if (sel < 55) begin
      return pack_item(int'($urandom_range(0, 4000)) - 2000,
                       int'($urandom_range(0, 4000)) - 2000,
                       -int'($urandom_range(12000, 20000)),
                       int'($urandom_range(0, 1200)) - 600,
                       int'($urandom_range(0, 1200)) - 600,
                       int'($urandom_range(0, 1200)) - 600);
    end else if (sel < 75) begin
      return pack_item(ax, ay, az, rand_s16(), rand_s16(), rand_s16());
    end else if (sel < 85) begin
      return pack_item(int'($urandom_range(0, 4)) - 2, int'($urandom_range(0, 4)) - 2,
                       int'($urandom_range(0, 4)) - 2, int'($urandom_range(0, 4)) - 2,
                       int'($urandom_range(0, 4)) - 2, int'($urandom_range(0, 4)) - 2);
    end else if (sel < 92) begin
      // Field parallel to gravity gives a zero west vector.
      k = int'($urandom_range(0, 6)) - 3;
      ax = int'($urandom_range(0, 8000)) - 4000;
      ay = int'($urandom_range(0, 8000)) - 4000;
      az = int'($urandom_range(0, 8000)) - 4000;
      return pack_item(ax, ay, az, k * ax, k * ay, k * az);
    end else begin
      // Gravity along x: the heading direction is undefined.
      return pack_item(rand_s16(), 0, 0, rand_s16(), rand_s16(), rand_s16());
    end
  endfunction

  ech_in_t directed_items[$];

  initial begin
    int sent, burst;
    sb          = new();
    cycle_cnt   = 0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_stall_i = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    // Directed part: extremes, zero cross products, undefined direction,
    // headings right around north where the full turn wraps to zero.
    directed_items.push_back(pack_item(0, 0, 0, 0, 0, 0));
    directed_items.push_back(pack_item(0, 0, -16384, 0, 0, 0));
    directed_items.push_back(pack_item(0, 0, 0, 500, -300, 200));
    directed_items.push_back(pack_item(100, -200, 300, -200, 400, -600));
    directed_items.push_back(pack_item(-1000, 0, 0, 0, 500, 100));
    directed_items.push_back(pack_item(32767, 0, 0, -32768, 32767, -32768));
    directed_items.push_back(pack_item(-32768, -32768, -32768, -32768, -32768, -32768));
    directed_items.push_back(pack_item(32767, 32767, 32767, 32767, 32767, 32767));
    directed_items.push_back(pack_item(-32768, 32767, -32768, 32767, -32768, 32767));
    directed_items.push_back(pack_item(32767, -32768, 32767, -32768, 32767, -32768));
    directed_items.push_back(pack_item(-32768, -32768, -32768, 32767, 32767, 32767));
    directed_items.push_back(pack_item(0, 0, -16384, 1000, 0, 0));
    directed_items.push_back(pack_item(0, 0, -16384, 1000, 1, 0));
    directed_items.push_back(pack_item(0, 0, -16384, 1000, -1, 0));
    directed_items.push_back(pack_item(0, 0, -16384, 32767, -1, 5));
    directed_items.push_back(pack_item(0, 0, -16384, -1000, 0, 0));
    directed_items.push_back(pack_item(0, 0, -16384, 0, 1000, 0));
    directed_items.push_back(pack_item(0, 0, -16384, 0, -1000, 0));
    directed_items.push_back(pack_item(0, 0, -16384, -1000, 1, 0));
    directed_items.push_back(pack_item(0, 0, 16384, 700, -700, 300));
    directed_items.push_back(pack_item(1, 1, 1, -1, -1, 1));
    foreach (directed_items[i]) send_item(directed_items[i]);
    idle_gap(1);

    // Hold off until the pipeline has fully drained once.
    while (sb.pending() != 0) @(negedge clk_i);

    sent = 0;
    while (sent < RandomItems) begin
      burst = $urandom_range(1, 40);
      for (int j = 0; j < burst && sent < RandomItems; j++) begin
        send_item(random_item());
        sent++;
      end
      if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(0, 6));
    end
    idle_gap(1);

    while (sb.pending() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
